>>> rtl/xfrd_pkg.sv
`default_nettype none

package xfrd_pkg;

    // Body store
    localparam int BODY_DEPTH = 256;
    localparam int ADDR_W     = $clog2(BODY_DEPTH);
    localparam int POS_W      = ADDR_W + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Framing bytes
    localparam logic [7:0] HDR_LEAD   = 8'h19;
    localparam logic [7:0] HDR_ALT_A  = 8'h34;
    localparam logic [7:0] HDR_ALT_B  = 8'h38;
    localparam logic [7:0] ACK_BYTE   = 8'ha5;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TYPE1  = 3'd1,
        PH_TYPE2  = 3'd2,
        PH_LENLO  = 3'd3,
        PH_LENHI  = 3'd4,
        PH_BODY   = 3'd5,
        PH_CSUM   = 3'd6,
        PH_ACK    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        EV_BODY     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_CSUM_ERR = 3'd2,
        EV_OVERFLOW = 3'd3,
        EV_ACK_OK   = 3'd4,
        EV_ACK_MISS = 3'd5
    } event_kind_t;

    typedef struct packed {
        event_kind_t         op;
        logic [7:0]          data;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          lead;
        logic [7:0]          follow;
        logic [7:0]          type_one;
        logic [7:0]          type_two;
        logic [15:0]         length;
        logic                type_diff;
    } evt_entry_t;

    function automatic logic is_alt_hdr(input logic [7:0] b);
        is_alt_hdr = (b == HDR_ALT_A) || (b == HDR_ALT_B);
    endfunction

    function automatic logic uses_store(input event_kind_t op);
        uses_store = (op == EV_BODY) || (op == EV_OVERFLOW);
    endfunction

endpackage

`default_nettype wire

>>> rtl/xfrd_rx_if.sv
`default_nettype none

interface xfrd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/xfrd_evt_if.sv
`default_nettype none

interface xfrd_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  body_byte;
    logic [7:0]  body_index;
    logic [7:0]  header_lead;
    logic [7:0]  header_follow;
    logic [7:0]  type_first;
    logic [7:0]  type_second;
    logic [15:0] body_length;
    logic        is_unique;
    logic        send_ack;
    logic        deliver;

    modport source (
        output valid, output event_kind, output body_byte, output body_index,
        output header_lead, output header_follow, output type_first,
        output type_second, output body_length, output is_unique,
        output send_ack, output deliver,
        input  ready
    );
    modport sink (
        input  valid, input event_kind, input body_byte, input body_index,
        input  header_lead, input header_follow, input type_first,
        input  type_second, input body_length, input is_unique,
        input  send_ack, input deliver,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/xfrd_front.sv
`default_nettype none

module xfrd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    xfrd_rx_if.sink                rx,
    input  wire logic              q_full,
    output logic                   push,
    output xfrd_pkg::evt_entry_t   push_entry
);

    xfrd_pkg::phase_t                phase_reg, phase_next;
    logic [7:0]                      last_reg, last_next;
    logic [7:0]                      xor_reg, xor_next;
    logic [7:0]                      lead_reg, lead_next;
    logic [7:0]                      follow_reg, follow_next;
    logic [7:0]                      type1_reg, type1_next;
    logic [7:0]                      type2_reg, type2_next;
    logic [15:0]                     length_reg, length_next;
    logic [xfrd_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                            tdiff_reg, tdiff_next;

    logic                            accept;
    logic [7:0]                      b;
    logic                            hdr_hit;
    logic [xfrd_pkg::POS_W-1:0]      pos_inc;
    logic                            body_full;
    logic [15:0]                     len_full;

    assign rx.ready  = !q_full;
    assign accept    = rx.valid && !q_full;
    assign b         = rx.rx_byte;
    assign pos_inc   = pos_reg + 1'b1;
    assign body_full = (pos_inc == xfrd_pkg::POS_W'(xfrd_pkg::BODY_DEPTH));
    assign len_full  = {b, length_reg[7:0]};
    assign hdr_hit   = (xfrd_pkg::is_alt_hdr(b) && last_reg == xfrd_pkg::HDR_LEAD)
                    || (b == xfrd_pkg::HDR_LEAD && xfrd_pkg::is_alt_hdr(last_reg));

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                xfrd_pkg::PH_HEADER: if (hdr_hit) phase_next = xfrd_pkg::PH_TYPE1;
                xfrd_pkg::PH_TYPE1:  phase_next = xfrd_pkg::PH_TYPE2;
                xfrd_pkg::PH_TYPE2:  phase_next = xfrd_pkg::PH_LENLO;
                xfrd_pkg::PH_LENLO:  phase_next = xfrd_pkg::PH_LENHI;
                xfrd_pkg::PH_LENHI:
                    phase_next = (len_full == 16'd0) ? xfrd_pkg::PH_CSUM
                                                     : xfrd_pkg::PH_BODY;
                xfrd_pkg::PH_BODY:
                begin
                    if (body_full)
                        phase_next = xfrd_pkg::PH_HEADER;
                    else if (16'(pos_inc) == length_reg)
                        phase_next = xfrd_pkg::PH_CSUM;
                end
                xfrd_pkg::PH_CSUM:
                    phase_next = (xor_reg != b) ? xfrd_pkg::PH_HEADER : xfrd_pkg::PH_ACK;
                default: phase_next = xfrd_pkg::PH_HEADER;
            endcase
        end
    end

    // Outputs: build the event handed to the back part
    always_comb
    begin
        push                 = 1'b0;
        push_entry.op        = xfrd_pkg::EV_BODY;
        push_entry.data      = 8'd0;
        push_entry.addr      = '0;
        push_entry.lead      = lead_reg;
        push_entry.follow    = follow_reg;
        push_entry.type_one  = type1_reg;
        push_entry.type_two  = type2_reg;
        push_entry.length    = length_reg;
        push_entry.type_diff = tdiff_reg;
        if (accept)
        begin
            case (phase_reg)
                xfrd_pkg::PH_BODY:
                begin
                    push            = 1'b1;
                    push_entry.op   = body_full ? xfrd_pkg::EV_OVERFLOW : xfrd_pkg::EV_BODY;
                    push_entry.data = b;
                    push_entry.addr = pos_reg[xfrd_pkg::ADDR_W-1:0];
                end
                xfrd_pkg::PH_CSUM:
                begin
                    push          = 1'b1;
                    push_entry.op = (xor_reg != b) ? xfrd_pkg::EV_CSUM_ERR : xfrd_pkg::EV_GOOD;
                end
                xfrd_pkg::PH_ACK:
                begin
                    push          = 1'b1;
                    push_entry.op = (b == xfrd_pkg::ACK_BYTE) ? xfrd_pkg::EV_ACK_OK
                                                              : xfrd_pkg::EV_ACK_MISS;
                end
                default: push = 1'b0;
            endcase
        end
    end

    // Frame registers
    always_comb
    begin
        last_next   = last_reg;
        xor_next    = xor_reg;
        lead_next   = lead_reg;
        follow_next = follow_reg;
        type1_next  = type1_reg;
        type2_next  = type2_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        tdiff_next  = tdiff_reg;
        if (accept)
        begin
            last_next = b;
            if (phase_reg != xfrd_pkg::PH_CSUM)
                xor_next = xor_reg ^ b;
            case (phase_reg)
                xfrd_pkg::PH_HEADER:
                begin
                    if (hdr_hit)
                    begin
                        lead_next   = last_reg;
                        follow_next = b;
                        xor_next    = last_reg ^ b;
                        tdiff_next  = 1'b0;
                        pos_next    = '0;
                    end
                end
                xfrd_pkg::PH_TYPE1:
                begin
                    tdiff_next = (type1_reg != b);
                    type1_next = b;
                end
                xfrd_pkg::PH_TYPE2:
                begin
                    tdiff_next = tdiff_reg | (type2_reg != b);
                    type2_next = b;
                end
                xfrd_pkg::PH_LENLO: length_next = {8'd0, b};
                xfrd_pkg::PH_LENHI: length_next = len_full;
                xfrd_pkg::PH_BODY:  pos_next    = pos_inc;
                default:            pos_next    = pos_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= xfrd_pkg::PH_HEADER;
            last_reg   <= 8'd0;
            xor_reg    <= 8'd0;
            lead_reg   <= 8'd0;
            follow_reg <= 8'd0;
            type1_reg  <= 8'd0;
            type2_reg  <= 8'd0;
            length_reg <= 16'd0;
            pos_reg    <= '0;
            tdiff_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            last_reg   <= last_next;
            xor_reg    <= xor_next;
            lead_reg   <= lead_next;
            follow_reg <= follow_next;
            type1_reg  <= type1_next;
            type2_reg  <= type2_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            tdiff_reg  <= tdiff_next;
        end
    end

    // In the body the position has not yet reached the declared length
    a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == xfrd_pkg::PH_BODY |-> 16'(pos_reg) < length_reg)
        else $error("body position at or beyond declared length");

endmodule

`default_nettype wire

>>> rtl/xfrd_queue.sv
`default_nettype none

module xfrd_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire xfrd_pkg::evt_entry_t   push_entry,
    output logic                        full,
    output logic                        empty,
    input  wire logic                   pop,
    output xfrd_pkg::evt_entry_t        head
);

    xfrd_pkg::evt_entry_t          slot_reg [xfrd_pkg::QUEUE_DEPTH];
    logic [xfrd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [xfrd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [xfrd_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    function automatic logic [xfrd_pkg::QPTR_W-1:0] ptr_inc(
        input logic [xfrd_pkg::QPTR_W-1:0] p);
        ptr_inc = (p == xfrd_pkg::QPTR_W'(xfrd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (cnt_reg == xfrd_pkg::QCNT_W'(xfrd_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("transfer written into a full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("entry taken from an empty queue");

endmodule

`default_nettype wire

>>> rtl/xfrd_back.sv
`default_nettype none

module xfrd_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    input  wire xfrd_pkg::evt_entry_t   q_head,
    output logic                        q_pop,
    xfrd_evt_if.source                  evt
);

    // Body store: one write and one registered read per cycle
    logic [7:0]                      store_mem [xfrd_pkg::BODY_DEPTH];
    logic [xfrd_pkg::BODY_DEPTH-1:0] store_vld_reg;
    logic [7:0]                      rdata_reg;
    logic                            rvld_reg;

    logic                            a_valid_reg, a_valid_next;
    xfrd_pkg::evt_entry_t            a_entry_reg;
    logic                            b_valid_reg, b_valid_next;
    xfrd_pkg::evt_entry_t            b_entry_reg;
    logic                            b_unique_reg;
    logic                            bdiff_reg, bdiff_next;

    logic                            a_adv;
    logic                            load_a;
    logic                            wr_en;
    logic [7:0]                      stored;
    logic                            mismatch;
    logic                            lead_phone;

    assign a_adv    = a_valid_reg && (!b_valid_reg || evt.ready);
    assign load_a   = !q_empty && (!a_valid_reg || a_adv);
    assign q_pop    = load_a;
    assign wr_en    = a_adv && xfrd_pkg::uses_store(a_entry_reg.op);
    assign stored   = rvld_reg ? rdata_reg : 8'd0;
    assign mismatch = (stored != a_entry_reg.data);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (load_a)
            a_valid_next = 1'b1;
        else if (a_adv)
            a_valid_next = 1'b0;

        b_valid_next = b_valid_reg;
        if (a_adv)
            b_valid_next = 1'b1;
        else if (evt.ready)
            b_valid_next = 1'b0;

        bdiff_next = bdiff_reg;
        if (a_adv)
        begin
            case (a_entry_reg.op)
                xfrd_pkg::EV_BODY:     bdiff_next = bdiff_reg | mismatch;
                xfrd_pkg::EV_OVERFLOW,
                xfrd_pkg::EV_GOOD,
                xfrd_pkg::EV_CSUM_ERR: bdiff_next = 1'b0;
                default:               bdiff_next = bdiff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            bdiff_reg     <= 1'b0;
            store_vld_reg <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            bdiff_reg   <= bdiff_next;
            if (wr_en)
                store_vld_reg[a_entry_reg.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_entry_reg <= q_head;
            rdata_reg   <= store_mem[q_head.addr];
            rvld_reg    <= store_vld_reg[q_head.addr];
        end
        if (wr_en)
            store_mem[a_entry_reg.addr] <= a_entry_reg.data;
        if (a_adv)
        begin
            b_entry_reg  <= a_entry_reg;
            b_unique_reg <= (a_entry_reg.op == xfrd_pkg::EV_GOOD)
                         && (a_entry_reg.type_diff || bdiff_reg);
        end
    end

    assign lead_phone        = (b_entry_reg.lead == xfrd_pkg::HDR_LEAD);

    assign evt.valid         = b_valid_reg;
    assign evt.event_kind    = b_entry_reg.op;
    assign evt.body_byte     = b_entry_reg.data;
    assign evt.body_index    = 8'(b_entry_reg.addr);
    assign evt.header_lead   = b_entry_reg.lead;
    assign evt.header_follow = b_entry_reg.follow;
    assign evt.type_first    = b_entry_reg.type_one;
    assign evt.type_second   = b_entry_reg.type_two;
    assign evt.body_length   = b_entry_reg.length;
    assign evt.is_unique     = b_unique_reg;
    assign evt.send_ack      = (b_entry_reg.op == xfrd_pkg::EV_GOOD) && lead_phone;
    assign evt.deliver       = (b_entry_reg.op == xfrd_pkg::EV_GOOD) && lead_phone
                            && b_unique_reg;

    // A store read never meets a write to the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        load_a && wr_en
        && (q_head.op == xfrd_pkg::EV_BODY || q_head.op == xfrd_pkg::EV_OVERFLOW)
        |-> q_head.addr != a_entry_reg.addr)
        else $error("store read and write hit the same entry");

    // The body mismatch flag is clear once a frame has closed
    a_bdiff_clear: assert property (@(posedge clk) disable iff (!rst_n)
        a_adv && (a_entry_reg.op == xfrd_pkg::EV_GOOD
                  || a_entry_reg.op == xfrd_pkg::EV_CSUM_ERR
                  || a_entry_reg.op == xfrd_pkg::EV_OVERFLOW)
        |=> !bdiff_reg)
        else $error("body mismatch flag survived the end of a frame");

endmodule

`default_nettype wire

>>> rtl/xor_frame_receiver_dedup_unit.sv
`default_nettype none

// Serial frame receiver with duplicate detection. Takes one received byte per
// transfer on rx and hunts for a two-byte header (0x19 with 0x34 or 0x38, in
// either order), then reads two type bytes, a little-endian 16-bit length,
// the body, an XOR checksum byte and an acknowledgement byte. Each body byte
// leaves on evt with its index; the checksum byte yields a frame-good or a
// checksum-error event, and the byte after a good frame yields ack received
// (0xa5) or ack missing. A frame is marked unique when its type bytes or
// body differ from those of the previous frame; the body is kept in a
// 256-entry store that reads as zero after reset through per-entry valid
// bits, so no clearing pass is needed. A body reaching the store depth ends
// with an overflow event. One byte is taken every cycle while the queue has
// room; a result passes through a queue slot, the store read and the
// output register before it is offered on evt, the store's registered read
// setting the depth of the back part. Header, type and length bytes produce
// no result.
module xor_frame_receiver_dedup_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    xfrd_rx_if.sink    rx,
    xfrd_evt_if.source evt
);

    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    xfrd_pkg::evt_entry_t  q_push_entry;
    xfrd_pkg::evt_entry_t  q_head;

    // Decode the byte stream, track the frame, hand results to the queue
    xfrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    // Hold pending events so either side may stall on its own
    xfrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .empty      (q_empty),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Compare and update the body store, drive the result register
    xfrd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .evt     (evt)
    );

endmodule

`default_nettype wire

>>> tb/tb_xor_frame_receiver_dedup_unit.sv
module tb_xor_frame_receiver_dedup_unit;

    // Run sizing: the limits below leave a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 650;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_REPORTS    = 10;
    localparam int PRESSURE_FRAME = 3;
    localparam int OVERFLOW_FRAME = 8;
    localparam int QUIET_FRAME    = 20;
    localparam int SCRIPT_ROWS    = 26;

    // One event as it leaves the evt channel.
    typedef struct packed {
        xfrd_pkg::event_kind_t kind;
        logic [7:0]            body_byte;
        logic [7:0]            body_index;
        logic [7:0]            lead;
        logic [7:0]            follow;
        logic [7:0]            type_one;
        logic [7:0]            type_two;
        logic [15:0]           length;
        logic                  is_unique;
        logic                  send_ack;
        logic                  deliver;
    } frame_event_t;

    // Where a scripted byte comes from, and how its outcome is checked.
    typedef enum logic { SRC_LITERAL, SRC_CHECKSUM } row_src_t;
    typedef enum logic { CHK_MODEL, CHK_TYPED } row_check_t;
    typedef enum logic [1:0] { PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_CADENCE } pace_t;

    typedef struct {
        logic [7:0]   value;
        row_src_t     src;
        row_check_t   chk;
        bit           has_event;
        frame_event_t ev;
    } stim_row_t;

    // Outcomes that can be read straight off the framing rules.
    localparam frame_event_t NO_EVENT = '0;
    localparam frame_event_t FIRST_GOOD = '{xfrd_pkg::EV_GOOD, 8'h00, 8'h00,
        xfrd_pkg::HDR_LEAD, xfrd_pkg::HDR_ALT_A, 8'h00, 8'h00, 16'd0, 1'b0, 1'b1, 1'b0};
    localparam frame_event_t FIRST_ACK  = '{xfrd_pkg::EV_ACK_OK, 8'h00, 8'h00,
        xfrd_pkg::HDR_LEAD, xfrd_pkg::HDR_ALT_A, 8'h00, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0};
    localparam frame_event_t SECOND_BAD = '{xfrd_pkg::EV_CSUM_ERR, 8'h00, 8'h00,
        xfrd_pkg::HDR_ALT_B, xfrd_pkg::HDR_LEAD, 8'hff, 8'hff, 16'd2, 1'b0, 1'b0, 1'b0};

    logic clk = 1'b0;
    logic rst_n;

    xfrd_rx_if  rx ();
    xfrd_evt_if evt ();

    xor_frame_receiver_dedup_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .evt   (evt)
    );

    always #2 clk = ~clk;

    // Shadow of the receiver: framing phase, checksum and the body kept
    // from the previous frame for duplicate detection.
    xfrd_pkg::phase_t rx_phase;
    logic [7:0]  prev_byte;
    logic [7:0]  xor_acc;
    logic [7:0]  lead_q;
    logic [7:0]  follow_q;
    logic [7:0]  type_one_q;
    logic [7:0]  type_two_q;
    logic [15:0] length_q;
    logic [8:0]  body_pos;
    logic        differs;
    logic [7:0]  body_mem [xfrd_pkg::BODY_DEPTH];

    frame_event_t pending_events [$];
    stim_row_t    script [SCRIPT_ROWS];

    int  fault_count = 0;
    int  items_sent  = 0;
    int  burst_left  = 0;
    int  cycle_count = 0;
    bit  hold_request = 1'b0;

    function automatic string show_event(input frame_event_t e);
        return $sformatf({"kind=%0d byte=%02h idx=%0d hdr=%02h/%02h types=%02h/%02h",
                          " len=%0d uniq=%b ack=%b dlv=%b"},
                         e.kind, e.body_byte, e.body_index, e.lead, e.follow,
                         e.type_one, e.type_two, e.length, e.is_unique, e.send_ack, e.deliver);
    endfunction

    // Advance the shadow by one received byte and work out the event it
    // raises, if any.
    task automatic decode_rx_byte(input logic [7:0] b, output bit got, output frame_event_t ev);
        logic [8:0] slot;
        ev   = '0;
        got  = 1'b0;
        slot = body_pos;
        // The checksum byte itself is the only one left out of the sum.
        if (rx_phase != xfrd_pkg::PH_CSUM)
            xor_acc ^= b;
        case (rx_phase)
            xfrd_pkg::PH_HEADER:
            begin
                // Lead byte with either alternate, in either order.
                if (((b == xfrd_pkg::HDR_ALT_A || b == xfrd_pkg::HDR_ALT_B)
                     && prev_byte == xfrd_pkg::HDR_LEAD) ||
                    (b == xfrd_pkg::HDR_LEAD && (prev_byte == xfrd_pkg::HDR_ALT_A
                                                 || prev_byte == xfrd_pkg::HDR_ALT_B)))
                begin
                    rx_phase = xfrd_pkg::PH_TYPE1;
                    lead_q   = prev_byte;
                    follow_q = b;
                    xor_acc  = prev_byte ^ b;
                    differs  = 1'b0;
                    body_pos = '0;
                end
            end
            xfrd_pkg::PH_TYPE1:
            begin
                differs    = (type_one_q != b);
                type_one_q = b;
                rx_phase   = xfrd_pkg::PH_TYPE2;
            end
            xfrd_pkg::PH_TYPE2:
            begin
                differs    = differs | (type_two_q != b);
                type_two_q = b;
                rx_phase   = xfrd_pkg::PH_LENLO;
            end
            xfrd_pkg::PH_LENLO:
            begin
                length_q = {8'h00, b};
                rx_phase = xfrd_pkg::PH_LENHI;
            end
            xfrd_pkg::PH_LENHI:
            begin
                length_q[15:8] = b;
                rx_phase = (length_q == 16'd0) ? xfrd_pkg::PH_CSUM : xfrd_pkg::PH_BODY;
            end
            xfrd_pkg::PH_BODY:
            begin
                differs = differs | (body_mem[slot[7:0]] != b);
                body_mem[slot[7:0]] = b;
                body_pos      = slot + 9'd1;
                got           = 1'b1;
                ev.body_byte  = b;
                ev.body_index = slot[7:0];
                // A full store wins over a body that ends on the same byte.
                if (body_pos >= xfrd_pkg::BODY_DEPTH)
                begin
                    ev.kind  = xfrd_pkg::EV_OVERFLOW;
                    rx_phase = xfrd_pkg::PH_HEADER;
                end
                else
                begin
                    ev.kind = xfrd_pkg::EV_BODY;
                    if ({7'd0, body_pos} == length_q)
                        rx_phase = xfrd_pkg::PH_CSUM;
                end
            end
            xfrd_pkg::PH_CSUM:
            begin
                got = 1'b1;
                if (xor_acc != b)
                begin
                    ev.kind  = xfrd_pkg::EV_CSUM_ERR;
                    rx_phase = xfrd_pkg::PH_HEADER;
                end
                else
                begin
                    ev.kind      = xfrd_pkg::EV_GOOD;
                    ev.is_unique = differs;
                    ev.send_ack  = (lead_q == xfrd_pkg::HDR_LEAD);
                    ev.deliver   = (lead_q == xfrd_pkg::HDR_LEAD) && differs;
                    rx_phase     = xfrd_pkg::PH_ACK;
                end
            end
            default:
            begin
                got      = 1'b1;
                ev.kind  = (b == xfrd_pkg::ACK_BYTE) ? xfrd_pkg::EV_ACK_OK
                                                     : xfrd_pkg::EV_ACK_MISS;
                rx_phase = xfrd_pkg::PH_HEADER;
            end
        endcase
        ev.lead     = lead_q;
        ev.follow   = follow_q;
        ev.type_one = type_one_q;
        ev.type_two = type_two_q;
        ev.length   = length_q;
        prev_byte   = b;
    endtask

    // Offer one byte on rx in bursts with random gaps, hold it until the
    // transfer completes, then queue whatever event it is due to raise.
    task automatic feed_rx_byte(input logic [7:0] value, input bit typed = 1'b0,
                                input bit typed_has = 1'b0,
                                input frame_event_t typed_ev = '0);
        int gap;
        bit has;
        frame_event_t ev;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                rx.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx.valid   <= 1'b1;
        rx.rx_byte <= value;
        do @(posedge clk); while (rx.ready !== 1'b1);
        items_sent++;
        decode_rx_byte(value, has, ev);
        // Scripted rows with a written-out outcome take it in place of the shadow's.
        if (typed)
        begin
            has = typed_has;
            ev  = typed_ev;
        end
        if (has)
            pending_events.push_back(ev);
    endtask

    // Hard stop: no legal run gets anywhere near this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** xor_frame_receiver_dedup_unit: FAILED **");
            $finish;
        end
    end

    // Compare every event transfer with the oldest one still owed; report
    // the first few faults in full and merely count the rest.
    always @(posedge clk)
    begin
        frame_event_t seen;
        frame_event_t want;
        if (rst_n && evt.valid === 1'b1 && evt.ready === 1'b1)
        begin
            seen = {evt.event_kind, evt.body_byte, evt.body_index, evt.header_lead,
                    evt.header_follow, evt.type_first, evt.type_second, evt.body_length,
                    evt.is_unique, evt.send_ack, evt.deliver};
            if (pending_events.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected event: %s", show_event(seen));
            end
            else
            begin
                want = pending_events.pop_front();
                if (seen !== want)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("event mismatch\n  expected %s\n  actual   %s",
                                 show_event(want), show_event(seen));
                end
            end
        end
    end

    // Receiver pacing: spans of open flow, coin-toss stalls, sparse
    // acceptance and a fixed cadence; on request, hold off for a long
    // stretch so the block backs up and stalls its input.
    initial
    begin : sink_pacing
        int    hold_left;
        int    span;
        pace_t pace;
        hold_left = 0;
        span      = 0;
        pace      = PACE_OPEN;
        evt.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                evt.ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    pace = pace_t'($urandom_range(0, 3));
                    span = $urandom_range(8, 64);
                end
                span--;
                case (pace)
                    PACE_OPEN:   evt.ready <= 1'b1;
                    PACE_COIN:   evt.ready <= 1'($urandom_range(0, 1));
                    PACE_SPARSE: evt.ready <= ($urandom_range(0, 3) == 0);
                    default:     evt.ready <= (span % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0]  frame_q [$];
        logic [7:0]  pick;
        logic [7:0]  alt_b;
        logic [15:0] len;
        int          body_cnt;
        int          cut;
        int          flip_at;
        int          frame_no;
        bit          copy_body;

        rst_n      <= 1'b0;
        rx.valid   <= 1'b0;
        rx.rx_byte <= 8'h00;

        // Shadow starts from the reset state, body store cleared.
        rx_phase   = xfrd_pkg::PH_HEADER;
        prev_byte  = '0;
        xor_acc    = '0;
        lead_q     = '0;
        follow_q   = '0;
        type_one_q = '0;
        type_two_q = '0;
        length_q   = '0;
        body_pos   = '0;
        differs    = 1'b0;
        for (int i = 0; i < xfrd_pkg::BODY_DEPTH; i++)
            body_mem[i] = '0;

        // Directed frames: an empty phone frame straight after reset whose
        // types match the cleared registers (good, not unique, ack taken),
        // a reversed-order header with all-ones types and a two-byte body
        // ending in a checksum error, then a unique phone frame with its
        // ack missing.
        script = '{
            '{8'h19, SRC_LITERAL,  CHK_TYPED, 1'b0, NO_EVENT},
            '{8'h34, SRC_LITERAL,  CHK_TYPED, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_TYPED, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_TYPED, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_TYPED, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_TYPED, 1'b0, NO_EVENT},
            '{8'h2d, SRC_LITERAL,  CHK_TYPED, 1'b1, FIRST_GOOD},
            '{8'ha5, SRC_LITERAL,  CHK_TYPED, 1'b1, FIRST_ACK},
            '{8'h38, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h19, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'hff, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'hff, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h02, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'hff, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_TYPED, 1'b1, SECOND_BAD},
            '{8'h19, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h38, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'hff, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h01, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h5a, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h00, SRC_CHECKSUM, CHK_MODEL, 1'b0, NO_EVENT},
            '{8'h00, SRC_LITERAL,  CHK_MODEL, 1'b0, NO_EVENT}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            pick = (script[i].src == SRC_CHECKSUM) ? xor_acc : script[i].value;
            feed_rx_byte(pick, script[i].chk == CHK_TYPED, script[i].has_event, script[i].ev);
        end

        // Hold the sender until every directed event has drained.
        rx.valid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
        burst_left = 0;

        // Random frames: mostly well formed with random content, types and
        // bodies often copied from the previous frame so duplicates turn
        // up; some noise between frames, a few truncated frames, bad
        // checksums and missing acks; one frame long enough to overflow.
        items_sent = 0;
        frame_no   = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (frame_no == PRESSURE_FRAME)
                hold_request = 1'b1;
            if (frame_no == QUIET_FRAME)
            begin
                rx.valid <= 1'b0;
                do @(posedge clk); while (pending_events.size() != 0);
                burst_left = 0;
            end

            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 3))
                        0:       pick = xfrd_pkg::HDR_LEAD;
                        1:       pick = xfrd_pkg::ACK_BYTE;
                        default: pick = 8'($urandom);
                    endcase
                    feed_rx_byte(pick);
                end
            end

            alt_b = $urandom_range(0, 1) ? xfrd_pkg::HDR_ALT_B : xfrd_pkg::HDR_ALT_A;
            if ($urandom_range(0, 1))
                frame_q = '{xfrd_pkg::HDR_LEAD, alt_b};
            else
                frame_q = '{alt_b, xfrd_pkg::HDR_LEAD};
            frame_q.push_back(($urandom_range(0, 2) != 0) ? type_one_q : 8'($urandom));
            frame_q.push_back(($urandom_range(0, 2) != 0) ? type_two_q : 8'($urandom));

            if (frame_no == OVERFLOW_FRAME)
                len = $urandom_range(0, 1) ? 16'd256 : 16'($urandom_range(257, 65535));
            else
            begin
                case ($urandom_range(0, 9))
                    0:       len = 16'd0;
                    9:       len = 16'($urandom_range(9, 40));
                    default: len = 16'($urandom_range(1, 8));
                endcase
            end
            frame_q.push_back(len[7:0]);
            frame_q.push_back(len[15:8]);

            // Copy the stored body, at most one byte changed, or draw afresh.
            body_cnt  = (len >= xfrd_pkg::BODY_DEPTH) ? xfrd_pkg::BODY_DEPTH : int'(len);
            copy_body = $urandom_range(0, 1);
            flip_at   = $urandom_range(0, 2 * body_cnt);
            for (int i = 0; i < body_cnt; i++)
                frame_q.push_back((copy_body && i != flip_at) ? body_mem[i] : 8'($urandom));

            cut = frame_q.size();
            if ($urandom_range(0, 9) == 0)
                cut = $urandom_range(1, frame_q.size() - 1);
            for (int i = 0; i < cut; i++)
                feed_rx_byte(frame_q[i]);

            // Close complete frames with a checksum, now and then corrupted,
            // and an ack slot; an overflowed frame is already over.
            if (cut == frame_q.size() && body_cnt < xfrd_pkg::BODY_DEPTH)
            begin
                pick = xor_acc;
                if ($urandom_range(0, 7) == 0)
                    pick = pick ^ 8'($urandom_range(1, 255));
                feed_rx_byte(pick);
                feed_rx_byte(($urandom_range(0, 3) != 0) ? xfrd_pkg::ACK_BYTE : 8'($urandom));
            end
            frame_no++;
        end

        // Drain, then keep watching so any stray event can show.
        rx.valid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && pending_events.size() == 0)
            $display("** xor_frame_receiver_dedup_unit: PASSED **");
        else
            $display("** xor_frame_receiver_dedup_unit: FAILED **");
        $finish;
    end

endmodule
